// File: design/iic_pkg.sv
// ----------------------------------------------------------------------------
// iic_pkg
// Shared types and fixed widths of the image intensity centroid block.
// ----------------------------------------------------------------------------
package iic_pkg;

    // Fixed field widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 9;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Frame size after reset
    localparam logic [CFG_W-1:0] DIM_RESET = 9'd28;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Frame size as programmed
    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } dims_t;

endpackage

// File: design/iic_front.sv
// ----------------------------------------------------------------------------
// iic_front
// Raster position tracking and first-moment accumulation, one pixel a cycle.
// ----------------------------------------------------------------------------
module iic_front #(
    parameter int MAX_DIMENSION = 256,
    parameter int POS_W         = 8,
    parameter int TOT_W         = 24,
    parameter int MOM_W         = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  iic_pkg::dims_t            dims,
    input  logic                      pixel_valid,
    input  logic [iic_pkg::PIX_W-1:0] pixel,
    output logic                      last_pixel,
    output logic                      frame_done,
    output logic [TOT_W-1:0]          frame_total,
    output logic [MOM_W-1:0]          frame_mom_x,
    output logic [MOM_W-1:0]          frame_mom_y
);

    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int EW     = ((iic_pkg::CFG_W > DIM_W) ? iic_pkg::CFG_W : DIM_W) + 1;
    localparam int PROD_W = iic_pkg::PIX_W + POS_W;

    logic [POS_W-1:0]  col_reg;
    logic [POS_W-1:0]  row_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [MOM_W-1:0]  mom_x_reg;
    logic [MOM_W-1:0]  mom_y_reg;

    logic [EW-1:0]     w_raw;
    logic [EW-1:0]     h_raw;
    logic [EW-1:0]     w_eff;
    logic [EW-1:0]     h_eff;
    logic              last_col;
    logic              last_row;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;

    // Clamp the programmed size into 1..MAX_DIMENSION
    assign w_raw = EW'(dims.width);
    assign h_raw = EW'(dims.height);
    assign w_eff = (w_raw == '0) ? EW'(1) :
                   (w_raw > EW'(MAX_DIMENSION)) ? EW'(MAX_DIMENSION) : w_raw;
    assign h_eff = (h_raw == '0) ? EW'(1) :
                   (h_raw > EW'(MAX_DIMENSION)) ? EW'(MAX_DIMENSION) : h_raw;

    // Row and frame end, at or beyond the last position
    assign last_col   = (EW'(col_reg) + EW'(1)) >= w_eff;
    assign last_row   = (EW'(row_reg) + EW'(1)) >= h_eff;
    assign last_pixel = last_col & last_row;
    assign frame_done = pixel_valid & last_pixel;

    // Weight the pixel by its position
    assign prod_x = PROD_W'(pixel) * PROD_W'(col_reg);
    assign prod_y = PROD_W'(pixel) * PROD_W'(row_reg);

    // Sums including the current pixel
    assign frame_total = total_reg + TOT_W'(pixel);
    assign frame_mom_x = mom_x_reg + MOM_W'(prod_x);
    assign frame_mom_y = mom_y_reg + MOM_W'(prod_y);

    // Advance position, accumulate, clear at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            total_reg <= '0;
            mom_x_reg <= '0;
            mom_y_reg <= '0;
        end
        else if (pixel_valid)
        begin
            if (last_pixel)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                total_reg <= '0;
                mom_x_reg <= '0;
                mom_y_reg <= '0;
            end
            else
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + POS_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + POS_W'(1);
                end
                total_reg <= frame_total;
                mom_x_reg <= frame_mom_x;
                mom_y_reg <= frame_mom_y;
            end
        end
    end

    // Positions never pass the largest frame
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (EW'(col_reg) < EW'(MAX_DIMENSION)) && (EW'(row_reg) < EW'(MAX_DIMENSION)))
        else $error("iic_front: position beyond largest frame");

endmodule

// File: design/iic_div.sv
// ----------------------------------------------------------------------------
// iic_div
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module iic_div #(
    parameter int DEN_W = 24,
    parameter int Q_W   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DEN_W+Q_W-1:0]   dividend,
    input  logic [DEN_W-1:0]       divisor,
    output logic                   busy,
    output logic [Q_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   shift_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_next;
    logic [Q_W-1:0]   shift_next;

    // Trial subtract of the shifted remainder
    assign trial      = {rem_reg, shift_reg[Q_W-1]};
    assign ge         = trial >= {1'b0, den_reg};
    assign diff       = trial - {1'b0, den_reg};
    assign rem_next   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign shift_next = {shift_reg[Q_W-2:0], ge};

    assign busy     = busy_reg;
    assign quotient = shift_reg;

    // Control: load on start, count down the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(Q_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: high dividend part seeds the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg   <= divisor;
            rem_reg   <= dividend[DEN_W+Q_W-1:Q_W];
            shift_reg <= dividend[Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// File: design/iic_back.sv
// ----------------------------------------------------------------------------
// iic_back
// End-of-frame division of both moments and the one-deep result register.
// ----------------------------------------------------------------------------
module iic_back #(
    parameter int POS_W         = 8,
    parameter int TOT_W         = 24,
    parameter int MOM_W         = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  logic [TOT_W-1:0]          q_total,
    input  logic [MOM_W-1:0]          q_mom_x,
    input  logic [MOM_W-1:0]          q_mom_y,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [iic_pkg::OUT_W-1:0] center_x,
    output logic [iic_pkg::OUT_W-1:0] center_y,
    output logic                      empty_res
);

    localparam int Q_W   = POS_W + FRACTION_BITS;
    localparam int DIV_W = TOT_W + Q_W;
    localparam int OUT_W = iic_pkg::OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             zero_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] cx_reg;
    logic [OUT_W-1:0] cy_reg;
    logic             ez_reg;

    logic [DIV_W-1:0] dvd_x;
    logic [DIV_W-1:0] dvd_y;
    logic             busy_x;
    logic             busy_y;
    logic [Q_W-1:0]   quo_x;
    logic [Q_W-1:0]   quo_y;
    logic             sat_x;
    logic             sat_y;
    logic [OUT_W-1:0] cx_next;
    logic [OUT_W-1:0] cy_next;
    logic             taken;
    logic             out_free;
    logic             load;

    // Scale the moments by the fraction bits
    assign dvd_x = DIV_W'(q_mom_x) << FRACTION_BITS;
    assign dvd_y = DIV_W'(q_mom_y) << FRACTION_BITS;

    assign q_pop = (state_reg == ST_IDLE) & q_valid;

    iic_div #(
        .DEN_W (TOT_W),
        .Q_W   (Q_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (q_pop),
        .dividend (dvd_x),
        .divisor  (q_total),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    iic_div #(
        .DEN_W (TOT_W),
        .Q_W   (Q_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (q_pop),
        .dividend (dvd_y),
        .divisor  (q_total),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    // Saturate to the coordinate width, zero for an empty frame
    assign sat_x   = |(quo_x >> OUT_W);
    assign sat_y   = |(quo_y >> OUT_W);
    assign cx_next = zero_reg ? '0 : (sat_x ? '1 : OUT_W'(quo_x));
    assign cy_next = zero_reg ? '0 : (sat_y ? '1 : OUT_W'(quo_y));

    assign taken    = pop & out_valid_reg;
    assign out_free = ~out_valid_reg | taken;
    assign load     = (state_reg == ST_DONE) & out_free;

    // Sequence: take a frame, divide, hand over when the result slot frees
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!busy_x)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the empty flag and the result beat
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            zero_reg <= (q_total == '0);
        end
        if (load)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            ez_reg <= zero_reg;
        end
    end

    assign empty     = ~out_valid_reg;
    assign center_x  = cx_reg;
    assign center_y  = cy_reg;
    assign empty_res = ez_reg;

    // Both dividers finish together before hand-over
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!busy_x && !busy_y))
        else $error("iic_back: divider still busy at hand-over");

    // An empty frame gives zero coordinates
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ez_reg) |-> (cx_reg == '0 && cy_reg == '0))
        else $error("iic_back: empty frame with non-zero coordinates");

endmodule

// File: design/image_intensity_centroid.sv
// ----------------------------------------------------------------------------
// image_intensity_centroid
// Intensity centroid (first moments) of raster-order grayscale frames.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  pixels    push / full          pixel[7:0]
//  results   empty / pop          center_x[15:0], center_y[15:0], empty_res
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data[8:0]
//
//  One pixel is taken per cycle while full is low; the front accumulator sets that rate.
//  Each frame passes through the back end's idle, divide and done states, the
//  divide step set by the bit-serial dividers; a two-entry frame queue lets
//  this overlap the next frame.
//  full rises only on a frame's last pixel while both queue entries are held.
//  Reset clears all sums and positions at once; no clearing pass.
// ----------------------------------------------------------------------------
module image_intensity_centroid #(
    parameter int MAX_DIMENSION = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [iic_pkg::PIX_W-1:0]     pixel,
    output logic                          empty,
    input  logic                          pop,
    output logic [iic_pkg::OUT_W-1:0]     center_x,
    output logic [iic_pkg::OUT_W-1:0]     center_y,
    output logic                          empty_res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [iic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iic_pkg::CFG_W-1:0]     cfg_data
);

    localparam int POS_W  = $clog2(MAX_DIMENSION);
    localparam int TOT_W  = iic_pkg::PIX_W + 2 * POS_W;
    localparam int MOM_W  = TOT_W + POS_W;
    localparam int QDEPTH = 2;
    localparam int QP_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    iic_pkg::dims_t   dims_reg;

    logic             accept;
    logic             last_pixel;
    logic             frame_done;
    logic [TOT_W-1:0] frame_total;
    logic [MOM_W-1:0] frame_mom_x;
    logic [MOM_W-1:0] frame_mom_y;

    logic [TOT_W-1:0] q_tot_mem [QDEPTH];
    logic [MOM_W-1:0] q_mx_mem  [QDEPTH];
    logic [MOM_W-1:0] q_my_mem  [QDEPTH];
    logic [QP_W-1:0]  q_wr_reg;
    logic [QP_W-1:0]  q_rd_reg;
    logic [QC_W-1:0]  q_cnt_reg;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.width  <= iic_pkg::DIM_RESET;
            dims_reg.height <= iic_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (iic_pkg::cfg_reg_t'(cfg_index))
                iic_pkg::REG_FRAME_WIDTH:  dims_reg.width  <= cfg_data;
                iic_pkg::REG_FRAME_HEIGHT: dims_reg.height <= cfg_data;
                default:                   dims_reg        <= dims_reg;
            endcase
        end
    end

    // Stall only a frame-ending pixel that has no queue entry
    assign q_full  = (q_cnt_reg == QC_W'(QDEPTH));
    assign q_valid = (q_cnt_reg != '0);
    assign full    = q_full & last_pixel;
    assign accept  = push & ~full;

    iic_front #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .POS_W         (POS_W),
        .TOT_W         (TOT_W),
        .MOM_W         (MOM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .dims        (dims_reg),
        .pixel_valid (accept),
        .pixel       (pixel),
        .last_pixel  (last_pixel),
        .frame_done  (frame_done),
        .frame_total (frame_total),
        .frame_mom_x (frame_mom_x),
        .frame_mom_y (frame_mom_y)
    );

    // Frame queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (frame_done)
            begin
                q_wr_reg <= (q_wr_reg == QP_W'(QDEPTH - 1)) ? '0 : q_wr_reg + QP_W'(1);
            end
            if (q_pop)
            begin
                q_rd_reg <= (q_rd_reg == QP_W'(QDEPTH - 1)) ? '0 : q_rd_reg + QP_W'(1);
            end
            if (frame_done && !q_pop)
            begin
                q_cnt_reg <= q_cnt_reg + QC_W'(1);
            end
            else if (!frame_done && q_pop)
            begin
                q_cnt_reg <= q_cnt_reg - QC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            q_tot_mem[q_wr_reg] <= frame_total;
            q_mx_mem[q_wr_reg]  <= frame_mom_x;
            q_my_mem[q_wr_reg]  <= frame_mom_y;
        end
    end

    iic_back #(
        .POS_W         (POS_W),
        .TOT_W         (TOT_W),
        .MOM_W         (MOM_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_total   (q_tot_mem[q_rd_reg]),
        .q_mom_x   (q_mx_mem[q_rd_reg]),
        .q_mom_y   (q_my_mem[q_rd_reg]),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .center_x  (center_x),
        .center_y  (center_y),
        .empty_res (empty_res)
    );

    // A finished frame always finds a queue entry
    a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> !q_full)
        else $error("image_intensity_centroid: frame queue overflow");

    // The back end never takes from an empty queue
    a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("image_intensity_centroid: frame queue underflow");

endmodule
